[src/assert_macros.svh]
// assertion helpers used by lease_port_allocator_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define LPA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define LPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lpa_pkg.sv]
// ----------------------------------------------------------------------------
// lpa_pkg
// shared types and constants of the lease port allocator
// ----------------------------------------------------------------------------
package lpa_pkg;

  localparam int LPA_TABLE_SIZE = 32;

  localparam logic [15:0] RANGE_FIRST_RST = 16'd54300;
  localparam logic [15:0] RANGE_LAST_RST  = 16'd54320;
  localparam logic [15:0] LEASE_LIMIT_RST = 16'd120;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LAST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_EXTEND = 2'd2,
    OP_VIEW   = 2'd3
  } op_t;

  typedef logic [30:0] pid_t;
  typedef logic [15:0] tag_t;
  typedef logic [15:0] port_t;
  typedef logic [31:0] secs_t;

  typedef struct packed {
    pid_t  pid;
    tag_t  tag;
    secs_t start;
    secs_t renew;
    logic  renewed;
    secs_t stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic  kind;
    port_t port_out;
    logic  ok;
    pid_t  pid_out;
    tag_t  tag_out;
    secs_t start_time;
    secs_t renew_time;
    logic  renewed;
    logic  expired;
    logic  last;
  } result_t;

endpackage

[src/lpa_in_if.sv]
// ----------------------------------------------------------------------------
// lpa_in_if
// request channel: valid, ready and one request beat
// ----------------------------------------------------------------------------
interface lpa_in_if;
  import lpa_pkg::*;
  logic  valid;
  logic  ready;
  logic  [1:0] operation;
  pid_t  owner_pid;
  tag_t  owner_tag;
  port_t port;
  modport source (output valid, operation, owner_pid, owner_tag, port, input ready);
  modport sink (input valid, operation, owner_pid, owner_tag, port, output ready);
endinterface

[src/lpa_out_if.sv]
// ----------------------------------------------------------------------------
// lpa_out_if
// result channel: valid, ready and one result beat
// ----------------------------------------------------------------------------
interface lpa_out_if;
  import lpa_pkg::*;
  logic  valid;
  logic  ready;
  logic  kind;
  port_t port_out;
  logic  ok;
  pid_t  pid_out;
  tag_t  tag_out;
  secs_t start_time;
  secs_t renew_time;
  logic  renewed;
  logic  expired;
  logic  last;
  modport source (output valid, kind, port_out, ok, pid_out, tag_out, start_time,
                  renew_time, renewed, expired, last, input ready);
  modport sink (input valid, kind, port_out, ok, pid_out, tag_out, start_time,
                renew_time, renewed, expired, last, output ready);
endinterface

[src/lpa_cfg_if.sv]
// ----------------------------------------------------------------------------
// lpa_cfg_if
// register write channel: valid, ready, register index and data
// ----------------------------------------------------------------------------
interface lpa_cfg_if;
  import lpa_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/lpa_ram.sv]
// ----------------------------------------------------------------------------
// lpa_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module lpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic clk,
  input  logic we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

[src/lpa_age.sv]
// ----------------------------------------------------------------------------
// lpa_age
// lease age check: wrapping subtract and compare against the limit
// ----------------------------------------------------------------------------
module lpa_age (
  input  lpa_pkg::secs_t now,
  input  lpa_pkg::secs_t stamp,
  input  logic [15:0]    limit,
  output logic           expired
);
  import lpa_pkg::*;
  secs_t age;

  assign age     = now - stamp;
  assign expired = age > {16'd0, limit};
endmodule

[src/lease_port_allocator_core.sv]
// ----------------------------------------------------------------------------
// lease_port_allocator_core
// round-robin number allocator with expiring leases
// ----------------------------------------------------------------------------
// One request beat at a time. A tick is done in the accepting cycle, as is an
// extend of a number that is not held. An extend of a held number runs the
// accept, ram read, then merge and write back. An allocate accepts, then visits
// table entries of the range, each with an entry ram read, then an age check,
// up to TABLE_SIZE of them, and then hands over the reply. A view walks the
// held bits one index per cycle up to the last held entry and on each held
// entry moves to the hand-over state to pass on its beat; an empty table gives
// only a last beat. The reply states wait while the output register is full
// and out_ready is low. The entry ram read port and the single age compare unit
// set this order of steps. in_ready is high only while the sequencer is idle;
// a reply may still sit in the output register while the next request is
// taken. Held bits live in flops and clear at reset; no clearing pass is
// needed.
`include "assert_macros.svh"

module lease_port_allocator_core #(
  parameter int TABLE_SIZE = lpa_pkg::LPA_TABLE_SIZE
) (
  input logic      clk,
  input logic      rst_n,
  lpa_in_if.sink   in_bus,
  lpa_out_if.source out_bus,
  lpa_cfg_if.sink  cfg_bus
);
  import lpa_pkg::*;

  localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CNT_W = $clog2(TABLE_SIZE + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_A_RD, ST_A_CHK, ST_A_OUT, ST_X_RD, ST_X_WR, ST_V_SCAN, ST_V_OUT
  } state_t;

  // sequencer and configuration state
  state_t              state_r, state_nxt;
  port_t               range_first_r, range_first_nxt;
  port_t               range_last_r, range_last_nxt;
  logic [15:0]         lease_limit_r, lease_limit_nxt;
  logic [16:0]         np_r, np_nxt;
  secs_t               now_r, now_nxt;
  logic [TABLE_SIZE-1:0] held_r, held_nxt;
  port_t               p_r, p_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    visits_r, visits_nxt;
  pid_t                req_pid_r, req_pid_nxt;
  tag_t                req_tag_r, req_tag_nxt;
  logic                ok_r, ok_nxt;
  logic                empty_r, empty_nxt;
  logic                out_valid_r, out_valid_nxt;
  result_t             out_r, out_nxt;

  // entry ram
  logic   ram_we;
  entry_t ram_wdata;
  entry_t rd_entry;
  logic [ENTRY_W-1:0] ram_rdata;

  logic  age_expired;
  logic  in_fire, cfg_fire, out_free, out_load;
  port_t eff_last, p_start, p_wrap, ext_diff;
  logic [16:0] lim;
  logic [CNT_W-1:0] span;
  logic [TABLE_SIZE-1:0] above;
  logic  more_above;

  lpa_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );
  assign rd_entry = entry_t'(ram_rdata);

  // one age compare unit serves both the allocate scan and the view walk
  lpa_age u_age (
    .now     (now_r),
    .stamp   (rd_entry.stamp),
    .limit   (lease_limit_r),
    .expired (age_expired)
  );

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign cfg_fire = cfg_bus.valid && cfg_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;

  assign in_bus.ready  = (state_r == ST_IDLE);
  assign cfg_bus.ready = 1'b1;

  // effective range end: clamp to table span and to 16 bits, never below first
  always_comb begin
    lim = {1'b0, range_first_r} + 17'(TABLE_SIZE - 1);
    eff_last = range_last_r;
    if ({1'b0, range_last_r} > lim && lim <= 17'h0FFFF) begin
      eff_last = lim[15:0];
    end
    if (eff_last < range_first_r) begin
      eff_last = range_first_r;
    end
  end

  assign span = CNT_W'(eff_last - range_first_r);

  // a stale pointer outside the range restarts at the range start
  assign p_start = (np_r > {1'b0, eff_last} || np_r < {1'b0, range_first_r}) ?
                   range_first_r : np_r[15:0];
  assign p_wrap   = (p_r == eff_last) ? range_first_r : p_r + 16'd1;
  assign ext_diff = in_bus.port - range_first_r;

  // held entries past the current view index decide the last flag
  always_comb begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      above[i] = held_r[i] && (i > int'(idx_r));
    end
  end
  assign more_above = |above;

  always_comb begin
    state_nxt       = state_r;
    range_first_nxt = range_first_r;
    range_last_nxt  = range_last_r;
    lease_limit_nxt = lease_limit_r;
    np_nxt          = np_r;
    now_nxt         = now_r;
    held_nxt        = held_r;
    p_nxt           = p_r;
    idx_nxt         = idx_r;
    visits_nxt      = visits_r;
    req_pid_nxt     = req_pid_r;
    req_tag_nxt     = req_tag_r;
    ok_nxt          = ok_r;
    empty_nxt       = empty_r;
    out_nxt         = out_r;
    out_load        = 1'b0;
    ram_we          = 1'b0;
    ram_wdata       = rd_entry;

    if (cfg_fire) begin
      case (cfg_bus.index)
        CFG_RANGE_FIRST: begin
          range_first_nxt = cfg_bus.data;
          np_nxt          = {1'b0, cfg_bus.data};
        end
        CFG_RANGE_LAST:  range_last_nxt  = cfg_bus.data;
        CFG_LEASE_LIMIT: lease_limit_nxt = cfg_bus.data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_pid_nxt = in_bus.owner_pid;
          req_tag_nxt = in_bus.owner_tag;
          case (op_t'(in_bus.operation))
            OP_TICK: now_nxt = now_r + 32'd1;
            OP_ALLOC: begin
              p_nxt      = p_start;
              idx_nxt    = IDX_W'(p_start - range_first_r);
              visits_nxt = '0;
              state_nxt  = ST_A_RD;
            end
            OP_EXTEND: begin
              if (in_bus.port >= range_first_r && ext_diff < 16'(TABLE_SIZE) &&
                  held_r[IDX_W'(ext_diff)]) begin
                idx_nxt   = IDX_W'(ext_diff);
                state_nxt = ST_X_RD;
              end
            end
            OP_VIEW: begin
              idx_nxt   = '0;
              empty_nxt = (held_r == '0);
              state_nxt = (held_r == '0) ? ST_V_OUT : ST_V_SCAN;
            end
            default: ;
          endcase
        end
      end

      ST_A_RD: state_nxt = ST_A_CHK;

      ST_A_CHK: begin
        if (!held_r[idx_r] || age_expired) begin
          // grant: fresh lease, no renewal yet
          ram_we            = 1'b1;
          ram_wdata.pid     = req_pid_r;
          ram_wdata.tag     = req_tag_r;
          ram_wdata.start   = now_r;
          ram_wdata.renew   = '0;
          ram_wdata.renewed = 1'b0;
          ram_wdata.stamp   = now_r;
          held_nxt[idx_r]   = 1'b1;
          np_nxt            = {1'b0, p_r} + 17'd1;
          ok_nxt            = 1'b1;
          state_nxt         = ST_A_OUT;
        end else if (visits_r == span) begin
          // whole range visited; pointer is back at the scan start
          np_nxt    = {1'b0, p_wrap};
          ok_nxt    = 1'b0;
          state_nxt = ST_A_OUT;
        end else begin
          p_nxt      = p_wrap;
          idx_nxt    = IDX_W'(p_wrap - range_first_r);
          visits_nxt = visits_r + CNT_W'(1);
          state_nxt  = ST_A_RD;
        end
      end

      ST_A_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_nxt  = '0;
          out_nxt.last = 1'b1;
          if (ok_r) begin
            out_nxt.port_out   = p_r;
            out_nxt.ok         = 1'b1;
            out_nxt.pid_out    = req_pid_r;
            out_nxt.tag_out    = req_tag_r;
            out_nxt.start_time = now_r;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_X_RD: state_nxt = ST_X_WR;

      ST_X_WR: begin
        ram_we            = 1'b1;
        ram_wdata.pid     = req_pid_r;
        ram_wdata.tag     = req_tag_r;
        ram_wdata.renew   = now_r;
        ram_wdata.renewed = 1'b1;
        ram_wdata.stamp   = now_r;
        state_nxt         = ST_IDLE;
      end

      ST_V_SCAN: begin
        // keep the index on a held entry so the ram read lands before the hand-over
        if (held_r[idx_r]) begin
          state_nxt = ST_V_OUT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      ST_V_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_nxt  = '0;
          out_nxt.kind = 1'b1;
          if (empty_r) begin
            out_nxt.last = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            out_nxt.port_out   = range_first_r + 16'(idx_r);
            out_nxt.ok         = 1'b1;
            out_nxt.pid_out    = rd_entry.pid;
            out_nxt.tag_out    = rd_entry.tag;
            out_nxt.start_time = rd_entry.start;
            out_nxt.renew_time = rd_entry.renew;
            out_nxt.renewed    = rd_entry.renewed;
            out_nxt.expired    = age_expired;
            out_nxt.last       = !more_above;
            if (more_above) begin
              idx_nxt   = idx_r + IDX_W'(1);
              state_nxt = ST_V_SCAN;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_bus.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      range_first_r <= RANGE_FIRST_RST;
      range_last_r  <= RANGE_LAST_RST;
      lease_limit_r <= LEASE_LIMIT_RST;
      np_r          <= {1'b0, RANGE_FIRST_RST};
      now_r         <= '0;
      held_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      range_first_r <= range_first_nxt;
      range_last_r  <= range_last_nxt;
      lease_limit_r <= lease_limit_nxt;
      np_r          <= np_nxt;
      now_r         <= now_nxt;
      held_r        <= held_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    p_r       <= p_nxt;
    idx_r     <= idx_nxt;
    visits_r  <= visits_nxt;
    req_pid_r <= req_pid_nxt;
    req_tag_r <= req_tag_nxt;
    ok_r      <= ok_nxt;
    empty_r   <= empty_nxt;
    out_r     <= out_nxt;
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.kind       = out_r.kind;
  assign out_bus.port_out   = out_r.port_out;
  assign out_bus.ok         = out_r.ok;
  assign out_bus.pid_out    = out_r.pid_out;
  assign out_bus.tag_out    = out_r.tag_out;
  assign out_bus.start_time = out_r.start_time;
  assign out_bus.renew_time = out_r.renew_time;
  assign out_bus.renewed    = out_r.renewed;
  assign out_bus.expired    = out_r.expired;
  assign out_bus.last       = out_r.last;

  // a reply never overwrites one still waiting in the output register
  `LPA_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_load, out_free, "reply overwritten")
  // the scan never visits more entries than the range holds
  `LPA_ASSERT_NOW(a_scan_bound, clk, rst_n, state_r == ST_A_CHK, visits_r <= span, "scan overrun")
  // leases are only ever granted, never dropped
  `LPA_ASSERT_NEXT(a_held_keep, clk, rst_n, 1'b1, (held_r & $past(held_r)) == $past(held_r), "held bit lost")
  // ram writes happen only on a grant or a renewal
  `LPA_ASSERT_NOW(a_we_state, clk, rst_n, ram_we, state_r == ST_A_CHK || state_r == ST_X_WR, "stray ram write")
endmodule
